FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the dispense control RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset as the disable condition.
`define MBSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define MBSD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `MBSD_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MBSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `MBSD_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/mbsd_pkg.sv
// Package for the multi-bin stepper dispense control block.
// Types, codes and reset constants; no dependencies.
package mbsd_pkg;

   localparam int BIN_COUNT_DEFAULT = 4;
   localparam int DOSE_COUNT        = 4;
   localparam int STEP_W            = 16;
   localparam int DROP_W            = 8;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;

   localparam logic [STEP_W-1:0] REV_LIMIT_RESET = 16'd800;

   // input op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_DROP  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // run_mode codes on the result word
   localparam logic [1:0] RUN_IDLE   = 2'd0;
   localparam logic [1:0] RUN_OPER   = 2'd1;
   localparam logic [1:0] RUN_REPORT = 2'd2;

   // register indexes (byte address 4*i)
   localparam logic [2:0] REG_DOSE0    = 3'd0;
   localparam logic [2:0] REG_DOSE1    = 3'd1;
   localparam logic [2:0] REG_DOSE2    = 3'd2;
   localparam logic [2:0] REG_DOSE3    = 3'd3;
   localparam logic [2:0] REG_REV_LIM  = 3'd4;
   localparam logic [2:0] REG_TMO_EN   = 3'd5;
   localparam logic [2:0] REG_PULSE_EN = 3'd6;

   typedef enum logic [3:0] {
      PH_PULSE  = 4'b0001,
      PH_CHECK  = 4'b0010,
      PH_WAIT   = 4'b0100,
      PH_REPORT = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_OPER   = 3'b010,
      MODE_REPORT = 3'b100
   } mode_type;

   typedef struct packed {
      logic [DOSE_COUNT-1:0][DROP_W-1:0] dose;
      logic [STEP_W-1:0]                 rev_limit;
      logic                              timeout_en;
      logic                              pulse_en;
   } cfg_type;

endpackage

FILE: rtl/core/mbsd_req_if.sv
// Input channel: valid/ready handshake carrying op and bin.
// Depends on nothing.
interface mbsd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [1:0] bin;

   modport source (output valid, op, bin, input ready);
   modport sink   (input valid, op, bin, output ready);
endinterface

FILE: rtl/core/mbsd_rsp_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on nothing.
interface mbsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       pulse_toggled;
   logic       pulse_level;
   logic       report_valid;
   logic       mismatch;
   logic [7:0] report_bin0;
   logic [7:0] report_bin1;
   logic [7:0] report_bin2;
   logic [7:0] report_bin3;
   logic [1:0] run_mode;

   modport source (output valid, pulse_toggled, pulse_level, report_valid, mismatch,
                   report_bin0, report_bin1, report_bin2, report_bin3, run_mode,
                   input ready);
   modport sink   (input valid, pulse_toggled, pulse_level, report_valid, mismatch,
                   report_bin0, report_bin1, report_bin2, report_bin3, run_mode,
                   output ready);
endinterface

FILE: rtl/core/mbsd_csr.sv
// APB-style configuration registers for the dispense control block.
// Depends on mbsd_pkg.
module mbsd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mbsd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbsd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbsd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output mbsd_pkg::cfg_type               cfg
);
   import mbsd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DOSE0:    cfg_in.dose[0]    = pwdata[DROP_W-1:0];
            REG_DOSE1:    cfg_in.dose[1]    = pwdata[DROP_W-1:0];
            REG_DOSE2:    cfg_in.dose[2]    = pwdata[DROP_W-1:0];
            REG_DOSE3:    cfg_in.dose[3]    = pwdata[DROP_W-1:0];
            REG_REV_LIM:  cfg_in.rev_limit  = pwdata[STEP_W-1:0];
            REG_TMO_EN:   cfg_in.timeout_en = pwdata[0];
            REG_PULSE_EN: cfg_in.pulse_en   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_DOSE0:    prdata = CSR_DATA_W'(cfg_ff.dose[0]);
         REG_DOSE1:    prdata = CSR_DATA_W'(cfg_ff.dose[1]);
         REG_DOSE2:    prdata = CSR_DATA_W'(cfg_ff.dose[2]);
         REG_DOSE3:    prdata = CSR_DATA_W'(cfg_ff.dose[3]);
         REG_REV_LIM:  prdata = CSR_DATA_W'(cfg_ff.rev_limit);
         REG_TMO_EN:   prdata = CSR_DATA_W'(cfg_ff.timeout_en);
         REG_PULSE_EN: prdata = CSR_DATA_W'(cfg_ff.pulse_en);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dose       <= '0;
         cfg_ff.rev_limit  <= REV_LIMIT_RESET;
         cfg_ff.timeout_en <= 1'b1;
         cfg_ff.pulse_en   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/multi_bin_stepper_dispense_control_unit.sv
// Top level of the multi-bin stepper dispense control block.
// Depends on mbsd_pkg, mbsd_req_if, mbsd_rsp_if, mbsd_csr and assert_macros.svh.
//
//   channel  | dir | handshake              | word
//   ---------+-----+------------------------+-----------------------------------
//   req_ch   | in  | valid & ready          | op, bin
//   rsp_ch   | out | valid & ready          | pulse/report fields, run_mode
//   csr_*    | in  | psel & penable & pwrite| 7 registers at 4*i, pready tied high
//
// One word per cycle unless a result is held; its result appears in the output register the next cycle.
// The whole per-bin update is one combinational pass into the state and result
// registers. req_ch.ready drops only while a result is held by rsp_ch.ready low.
// Synchronous reset clears bin state, mode and the output valid; no clearing pass.
`include "assert_macros.svh"

module multi_bin_stepper_dispense_control_unit #(
   parameter int BIN_COUNT = mbsd_pkg::BIN_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   mbsd_req_if.sink                        req_ch,
   mbsd_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mbsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbsd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import mbsd_pkg::*;

   localparam int BIN_IDX_W = $clog2(BIN_COUNT);

   cfg_type cfg;

   phase_type         phase_ff [BIN_COUNT];
   phase_type         phase_in [BIN_COUNT];
   logic [STEP_W-1:0] step_ff  [BIN_COUNT];
   logic [STEP_W-1:0] step_in  [BIN_COUNT];
   logic [DROP_W-1:0] drop_ff  [BIN_COUNT];
   logic [DROP_W-1:0] drop_in  [BIN_COUNT];
   logic [BIN_COUNT-1:0] pulse_ff, pulse_in;
   mode_type          mode_ff, mode_in;

   logic                 rsp_valid_ff;
   logic                 tog_ff, level_ff, rpt_ff, mism_ff;
   logic [DROP_W-1:0]    rep_ff [DOSE_COUNT];
   logic [DROP_W-1:0]    rep_in [DOSE_COUNT];
   logic [1:0]           run_ff, run_in;

   logic                 take;
   logic                 valid_bin;
   logic [BIN_IDX_W-1:0] bin_idx;
   logic [DROP_W-1:0]    dose_sel;
   logic [STEP_W-1:0]    step_inc;
   logic [BIN_COUNT-1:0] wait_vec, rpt_vec;
   logic                 all_wait, all_report;
   logic                 tog, rpt, mism;
   logic [DROP_W-1:0]    drop_pad [DOSE_COUNT];
   logic [DROP_W-1:0]    diff_pad [DOSE_COUNT];
   logic [DOSE_COUNT-1:0] diff_nz;

   mbsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_bin    = int'(req_ch.bin) < BIN_COUNT;
   assign bin_idx      = BIN_IDX_W'(req_ch.bin);
   assign dose_sel     = cfg.dose[req_ch.bin];
   assign step_inc     = step_ff[bin_idx] + STEP_W'(1);

   for (genvar g = 0; g < BIN_COUNT; g++) begin : g_phase_flags
      assign wait_vec[g] = (phase_ff[g] == PH_WAIT);
      assign rpt_vec[g]  = (phase_ff[g] == PH_REPORT);
   end
   assign all_wait   = &wait_vec;
   assign all_report = &rpt_vec;

   // report lanes: bins past BIN_COUNT read as zero and never mismatch
   for (genvar g = 0; g < DOSE_COUNT; g++) begin : g_report_lane
      if (g < BIN_COUNT) begin : g_live
         assign drop_pad[g] = drop_ff[g];
         assign diff_pad[g] = cfg.dose[g] - drop_ff[g];
      end else begin : g_dead
         assign drop_pad[g] = '0;
         assign diff_pad[g] = '0;
      end
      assign diff_nz[g] = (diff_pad[g] != '0);
   end
   assign mism = |diff_nz;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      drop_in  = drop_ff;
      pulse_in = pulse_ff;
      mode_in  = mode_ff;
      tog      = 1'b0;
      rpt      = 1'b0;
      if (take) begin
         case (req_ch.op)
            OP_START: begin
               for (int i = 0; i < BIN_COUNT; i++) begin
                  phase_in[i] = PH_PULSE;
                  step_in[i]  = '0;
                  drop_in[i]  = '0;
               end
               mode_in = MODE_OPER;
            end
            OP_DROP: begin
               if (valid_bin) begin
                  if (drop_ff[bin_idx] != '1)
                     drop_in[bin_idx] = drop_ff[bin_idx] + DROP_W'(1);
                  step_in[bin_idx] = '0;
                  if (phase_ff[bin_idx] == PH_PULSE)
                     phase_in[bin_idx] = PH_CHECK;
               end
            end
            OP_TICK: begin
               if (valid_bin && mode_ff == MODE_OPER) begin
                  unique case (phase_ff[bin_idx])
                     PH_PULSE: begin
                        if (cfg.pulse_en) begin
                           pulse_in[bin_idx] = !pulse_ff[bin_idx];
                           tog               = 1'b1;
                           phase_in[bin_idx] = PH_CHECK;
                           step_in[bin_idx]  = step_inc;
                        end
                     end
                     PH_CHECK: begin
                        step_in[bin_idx] = step_inc;
                        if (drop_ff[bin_idx] < dose_sel &&
                            (step_inc < cfg.rev_limit || !cfg.timeout_en))
                           phase_in[bin_idx] = PH_PULSE;
                        else
                           phase_in[bin_idx] = PH_WAIT;
                     end
                     PH_WAIT: begin
                        if (all_wait) begin
                           for (int i = 0; i < BIN_COUNT; i++)
                              phase_in[i] = PH_REPORT;
                           mode_in = MODE_REPORT;
                           rpt     = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < DOSE_COUNT; i++)
         rep_in[i] = !rpt ? '0 : (mism ? diff_pad[i] : drop_pad[i]);
   end

   always_comb begin
      unique case (mode_in)
         MODE_IDLE:   run_in = RUN_IDLE;
         MODE_OPER:   run_in = RUN_OPER;
         MODE_REPORT: run_in = RUN_REPORT;
         default:     run_in = RUN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BIN_COUNT; i++) begin
            phase_ff[i] <= PH_PULSE;
            step_ff[i]  <= '0;
            drop_ff[i]  <= '0;
         end
         pulse_ff     <= '0;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         drop_ff  <= drop_in;
         pulse_ff <= pulse_in;
         mode_ff  <= mode_in;
         if (take)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // result word: payload only, loaded on accept
   always_ff @(posedge clock) begin
      if (take) begin
         tog_ff   <= tog;
         level_ff <= valid_bin ? pulse_in[bin_idx] : 1'b0;
         rpt_ff   <= rpt;
         mism_ff  <= rpt && mism;
         rep_ff   <= rep_in;
         run_ff   <= run_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pulse_toggled = tog_ff;
   assign rsp_ch.pulse_level   = level_ff;
   assign rsp_ch.report_valid  = rpt_ff;
   assign rsp_ch.mismatch      = mism_ff;
   assign rsp_ch.report_bin0   = rep_ff[0];
   assign rsp_ch.report_bin1   = rep_ff[1];
   assign rsp_ch.report_bin2   = rep_ff[2];
   assign rsp_ch.report_bin3   = rep_ff[3];
   assign rsp_ch.run_mode      = run_ff;

   `MBSD_ASSERT_IMPL(a_report_mode, clock, reset, rsp_valid_ff && rpt_ff, mode_ff == MODE_REPORT, "report word outside report mode")
   `MBSD_ASSERT_IMPL(a_report_phases, clock, reset, mode_ff == MODE_REPORT, all_report, "report mode with a bin not in report phase")
   `MBSD_ASSERT_NEXT(a_pulse_hold, clock, reset, !take, $stable(pulse_ff), "pulse line moved without an accepted word")
   `MBSD_ASSERT_IMPL(a_tog_xor_rpt, clock, reset, rsp_valid_ff, !(tog_ff && rpt_ff), "toggle and report on one word")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_bin_stepper_dispense_control_unit: directed words, then
// random phases of dispense runs, checked against a per-bin predictor kept in this file.
// Depends on mbsd_pkg, mbsd_req_if, mbsd_rsp_if and the block's RTL.
module testbench;
   import mbsd_pkg::*;

   localparam logic [1:0] OP_SPARE     = 2'd3;
   localparam int         NUM_BINS     = 4;
   localparam int         TARGET_WORDS = 2000;
   localparam int         QUIET_LIMIT  = 4000;
   localparam int         HOLD_AT      = 700;
   localparam int         HOLD_CYCLES  = 300;

   typedef struct packed {
      logic       pulse_toggled;
      logic       pulse_level;
      logic       report_valid;
      logic       mismatch;
      logic [7:0] report_bin0;
      logic [7:0] report_bin1;
      logic [7:0] report_bin2;
      logic [7:0] report_bin3;
      logic [1:0] run_mode;
   } dispense_word_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        bin;
      logic              given;
      dispense_word_type word;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic accept_result = 1'b0;

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mbsd_req_if req_ch ();
   mbsd_rsp_if rsp_ch ();

   assign rsp_ch.ready = accept_result;

   multi_bin_stepper_dispense_control_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // predicted block state and register copies
   phase_type   bin_stage [NUM_BINS];
   logic [15:0] step_count [NUM_BINS];
   logic [7:0]  drop_count [NUM_BINS];
   logic        pulse_out [NUM_BINS];
   logic [1:0]  unit_mode;
   logic [7:0]  dose_set [NUM_BINS];
   logic [15:0] rev_limit_set;
   logic        timeout_on;
   logic        pulse_on;

   dispense_word_type expected_words [$];
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int quiet_cycles = 0;
   bit sender_calm = 1'b0;

   // columns: op, bin, given, {toggled, level, report_valid, mismatch}, report bytes 0..3, mode
   plan_row_type directed_plan [22] = '{
      {OP_TICK,  2'd0, 1'b1, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_SPARE, 2'd1, 1'b1, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_DROP,  2'd2, 1'b1, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_START, 2'd3, 1'b1, 4'b0000, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd0, 1'b1, 4'b1100, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd0, 1'b1, 4'b0100, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd0, 1'b1, 4'b0100, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd1, 1'b1, 4'b1100, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd1, 1'b1, 4'b0100, 32'h00000000, RUN_OPER},
      {OP_DROP,  2'd2, 1'b1, 4'b0000, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd2, 1'b1, 4'b0000, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd3, 1'b1, 4'b1100, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd3, 1'b1, 4'b0100, 32'h00000000, RUN_OPER},
      // all bins waiting; bin 2 has one drop over a zero dose, shortfall wraps
      {OP_TICK,  2'd3, 1'b1, 4'b0111, 32'h0000FF00, RUN_REPORT},
      {OP_TICK,  2'd3, 1'b1, 4'b0100, 32'h00000000, RUN_REPORT},
      {OP_DROP,  2'd1, 1'b1, 4'b0100, 32'h00000000, RUN_REPORT},
      // restart keeps pulse line levels
      {OP_START, 2'd0, 1'b1, 4'b0100, 32'h00000000, RUN_OPER},
      {OP_TICK,  2'd0, 1'b0, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_SPARE, 2'd0, 1'b0, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_DROP,  2'd0, 1'b0, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_DROP,  2'd3, 1'b0, 4'b0000, 32'h00000000, RUN_IDLE},
      {OP_TICK,  2'd0, 1'b0, 4'b0000, 32'h00000000, RUN_IDLE}
   };

   logic [2:0] reg_list [7] = '{REG_DOSE0, REG_DOSE1, REG_DOSE2, REG_DOSE3,
                                REG_REV_LIM, REG_TMO_EN, REG_PULSE_EN};

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic clear_prediction();
      for (int i = 0; i < NUM_BINS; i++) begin
         bin_stage[i]  = PH_PULSE;
         step_count[i] = '0;
         drop_count[i] = '0;
         pulse_out[i]  = 1'b0;
         dose_set[i]   = '0;
      end
      unit_mode     = RUN_IDLE;
      rev_limit_set = REV_LIMIT_RESET;
      timeout_on    = 1'b1;
      pulse_on      = 1'b1;
   endtask

   function automatic dispense_word_type predict_dispense(logic [1:0] op, logic [1:0] bin);
      dispense_word_type w;
      int waiting;
      logic [7:0] short_by [NUM_BINS];
      logic any_short;
      w = '0;
      waiting = 0;
      any_short = 1'b0;
      case (op)
         OP_START: begin
            for (int i = 0; i < NUM_BINS; i++) begin
               bin_stage[i]  = PH_PULSE;
               step_count[i] = '0;
               drop_count[i] = '0;
            end
            unit_mode = RUN_OPER;
         end
         OP_DROP: begin
            if (drop_count[bin] != 8'hFF) drop_count[bin]++;
            step_count[bin] = '0;
            if (bin_stage[bin] == PH_PULSE) bin_stage[bin] = PH_CHECK;
         end
         OP_TICK: begin
            if (unit_mode == RUN_OPER) begin
               case (bin_stage[bin])
                  PH_PULSE: begin
                     if (pulse_on) begin
                        pulse_out[bin]  = ~pulse_out[bin];
                        w.pulse_toggled = 1'b1;
                        bin_stage[bin]  = PH_CHECK;
                        step_count[bin]++;
                     end
                  end
                  PH_CHECK: begin
                     step_count[bin]++;
                     if (drop_count[bin] < dose_set[bin] &&
                         (step_count[bin] < rev_limit_set || !timeout_on))
                        bin_stage[bin] = PH_PULSE;
                     else
                        bin_stage[bin] = PH_WAIT;
                  end
                  PH_WAIT: begin
                     foreach (bin_stage[i]) if (bin_stage[i] == PH_WAIT) waiting++;
                     if (waiting == NUM_BINS) begin
                        foreach (bin_stage[i]) bin_stage[i] = PH_REPORT;
                        unit_mode      = RUN_REPORT;
                        w.report_valid = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      if (w.report_valid) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            short_by[i] = dose_set[i] - drop_count[i];
            if (short_by[i] != 0) any_short = 1'b1;
         end
         w.mismatch    = any_short;
         w.report_bin0 = any_short ? short_by[0] : drop_count[0];
         w.report_bin1 = any_short ? short_by[1] : drop_count[1];
         w.report_bin2 = any_short ? short_by[2] : drop_count[2];
         w.report_bin3 = any_short ? short_by[3] : drop_count[3];
      end
      w.pulse_level = pulse_out[bin];
      w.run_mode    = unit_mode;
      return w;
   endfunction

   // one input word; the expectation is queued at the accepting edge
   task automatic send_word(input logic [1:0] op, input logic [1:0] bin, input logic given,
                            input dispense_word_type given_word, output logic reported);
      int gap;
      dispense_word_type predicted;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.bin   <= bin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_dispense(op, bin);
      expected_words.push_back(given ? given_word : predicted);
      words_in++;
      reported = predicted.report_valid;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_DOSE0:    dose_set[0]   = value[7:0];
         REG_DOSE1:    dose_set[1]   = value[7:0];
         REG_DOSE2:    dose_set[2]   = value[7:0];
         REG_DOSE3:    dose_set[3]   = value[7:0];
         REG_REV_LIM:  rev_limit_set = value[15:0];
         REG_TMO_EN:   timeout_on    = value[0];
         REG_PULSE_EN: pulse_on      = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // phase 0 takes every register at its low end, phase 1 at its high end
   function automatic logic [31:0] pick_setting(logic [2:0] idx, int phase);
      int r;
      r = $urandom_range(0, 99);
      case (idx)
         REG_REV_LIM: begin
            if (phase == 0) return 32'd0;
            if (phase == 1) return 32'hFFFF;
            if (r < 10) return 32'd0;
            if (r < 20) return 32'd1;
            if (r < 27) return 32'hFFFF;
            if (r < 32) return 32'(REV_LIMIT_RESET);
            return $urandom_range(2, 40);
         end
         REG_TMO_EN: begin
            if (phase < 2) return 32'(phase);
            return 32'(r >= 25);
         end
         REG_PULSE_EN: begin
            if (phase < 2) return 32'(phase);
            return 32'(r >= 15);
         end
         default: begin
            if (phase == 0) return 32'd0;
            if (phase == 1) return 32'hFF;
            if (r < 10) return 32'd0;
            if (r < 18) return 32'hFF;
            return $urandom_range(1, 8);
         end
      endcase
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // usually a start, optional drop flood on one bin, then mostly ticks until just past a report or out of budget
   task automatic run_dispense(input bit flood);
      int budget;
      int tail;
      int r;
      logic [1:0] op;
      logic [1:0] flood_bin;
      logic reported;
      budget = $urandom_range(20, 200);
      tail = 0;
      flood_bin = 2'($urandom_range(0, 3));
      if (flood || $urandom_range(0, 19) != 0)
         send_word(OP_START, 2'($urandom_range(0, 3)), 1'b0, '0, reported);
      if (flood) begin
         repeat (270) begin
            if ($urandom_range(0, 99) < 88)
               send_word(OP_DROP, flood_bin, 1'b0, '0, reported);
            else
               send_word(OP_TICK, 2'($urandom_range(0, 3)), 1'b0, '0, reported);
         end
      end
      while (budget > 0 && tail < 3) begin
         r = $urandom_range(0, 99);
         op = (r < 80) ? OP_TICK : (r < 94) ? OP_DROP : (r < 99) ? OP_SPARE : OP_START;
         send_word(op, 2'($urandom_range(0, 3)), 1'b0, '0, reported);
         budget--;
         if (reported || tail > 0) tail++;
      end
   endtask

   initial begin
      logic reported;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_TICK;
      req_ch.bin   <= 2'd0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      clear_prediction();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_plan[i])
         send_word(directed_plan[i].op, directed_plan[i].bin, directed_plan[i].given,
                   directed_plan[i].word, reported);
      for (int phase = 0; words_in < TARGET_WORDS; phase++) begin
         wait_drained();
         foreach (reg_list[k])
            if (phase < 2 || $urandom_range(0, 4) < 3)
               csr_write(reg_list[k], pick_setting(reg_list[k], phase));
         sender_calm = ($urandom_range(0, 3) == 0);
         run_dispense(phase == 2 || $urandom_range(0, 24) == 0);
      end
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("multi_bin_stepper_dispense_control_unit: match");
      else
         $display("multi_bin_stepper_dispense_control_unit: mismatch");
      $finish;
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // result side: checks each word and throttles ready, with one long hold-off
   int  stall_left = 0;
   int  segment_left = 0;
   bit  calm = 1'b0;
   bit  held_once = 1'b0;

   always @(posedge clock) begin : result_monitor
      dispense_word_type want;
      if (reset) begin
         accept_result <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_out++;
            if (expected_words.size() == 0) begin
               $display("%0t: result word with nothing expected", $time);
               errors++;
            end else begin
               want = expected_words.pop_front();
               check_field("pulse_toggled", 8'(want.pulse_toggled), 8'(rsp_ch.pulse_toggled));
               check_field("pulse_level", 8'(want.pulse_level), 8'(rsp_ch.pulse_level));
               check_field("report_valid", 8'(want.report_valid), 8'(rsp_ch.report_valid));
               check_field("mismatch", 8'(want.mismatch), 8'(rsp_ch.mismatch));
               check_field("report_bin0", want.report_bin0, rsp_ch.report_bin0);
               check_field("report_bin1", want.report_bin1, rsp_ch.report_bin1);
               check_field("report_bin2", want.report_bin2, rsp_ch.report_bin2);
               check_field("report_bin3", want.report_bin3, rsp_ch.report_bin3);
               check_field("run_mode", 8'(want.run_mode), 8'(rsp_ch.run_mode));
            end
         end
         if (!held_once && words_out >= HOLD_AT) begin
            held_once = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (segment_left == 0) begin
            segment_left = $urandom_range(50, 400);
            calm = ($urandom_range(0, 3) == 0);
         end else begin
            segment_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            accept_result <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) < 4) begin
            stall_left = pick_gap();
            accept_result <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end else begin
            accept_result <= 1'b1;
         end
      end
   end

   // watchdog: any stretch with no word moved on either channel and no csr access
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("multi_bin_stepper_dispense_control_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mbsd_pkg.sv
rtl/core/mbsd_req_if.sv
rtl/core/mbsd_rsp_if.sv
rtl/core/mbsd_csr.sv
rtl/core/multi_bin_stepper_dispense_control_unit.sv
tb/sv/testbench.sv
